FILE: hw/rtl/u8d_pkg.sv
// Shared types and constants for the UTF-8 stream character decoder.
// Used by the front, queue, back and top-level modules; no dependencies.

package u8d_pkg;

  localparam int unsigned IndexBitsDefault = 16;
  localparam int unsigned QueueDepth       = 2;
  localparam int unsigned CpW              = 21;
  localparam int unsigned CountW           = 3;
  localparam int unsigned PosW             = 16;
  localparam int unsigned DataW            = 7;

  typedef enum logic [2:0] {
    K_ASCII,
    K_LEAD2,
    K_LEAD3,
    K_LEAD4,
    K_CONT,
    K_BAD
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_INVALID   = 2'd1,
    ST_TRUNC     = 2'd2,
    ST_AFTER_ERR = 2'd3
  } status_e;

  typedef struct packed {
    kind_e             kind;
    logic [DataW-1:0]  data;
    logic              last;
  } cls_t;

  typedef struct packed {
    logic [CpW-1:0]    cp;
    logic [CountW-1:0] cnt;
    logic [PosW-1:0]   pos;
    logic              sel;
    status_e           status;
    logic              last;
  } res_t;

  function automatic logic [CountW-1:0] lead_len(kind_e kind);
    logic [CountW-1:0] len;
    unique case (kind)
      K_LEAD2: len = CountW'(2);
      K_LEAD3: len = CountW'(3);
      K_LEAD4: len = CountW'(4);
      default: len = CountW'(1);
    endcase
    return len;
  endfunction

endpackage

FILE: hw/rtl/u8d_front.sv
// Front stage: accepts input bytes, classifies them and registers the result.
// Depends on u8d_pkg.

module u8d_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [7:0]    in_byte_i,
  input  logic          end_of_string_i,
  output logic          push_valid_o,
  input  logic          push_ready_i,
  output u8d_pkg::cls_t push_item_o
);
  import u8d_pkg::*;

  logic vld_q;
  cls_t cls_d, cls_q;

  assign in_ready_o = !vld_q || push_ready_i;

  always_comb begin
    cls_d.last = end_of_string_i;
    if ((in_byte_i & 8'h80) == 8'h00) begin
      cls_d.kind = K_ASCII;
      cls_d.data = in_byte_i[6:0];
    end else if ((in_byte_i & 8'hc0) == 8'h80) begin
      cls_d.kind = K_CONT;
      cls_d.data = {1'b0, in_byte_i[5:0] & 6'h3f};
    end else if ((in_byte_i & 8'he0) == 8'hc0) begin
      cls_d.kind = K_LEAD2;
      cls_d.data = {2'b0, in_byte_i[4:0] & 5'h1f};
    end else if ((in_byte_i & 8'hf0) == 8'he0) begin
      cls_d.kind = K_LEAD3;
      cls_d.data = {3'b0, in_byte_i[3:0] & 4'h0f};
    end else if ((in_byte_i & 8'hf8) == 8'hf0) begin
      cls_d.kind = K_LEAD4;
      cls_d.data = {4'b0, in_byte_i[2:0] & 3'h7};
    end else begin
      cls_d.kind = K_BAD;
      cls_d.data = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_ready_o) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cls_q <= cls_d;
    end
  end

  assign push_valid_o = vld_q;
  assign push_item_o  = cls_q;

endmodule

FILE: hw/rtl/u8d_queue.sv
// Short queue of classified bytes between front and back.
// Depends on u8d_pkg.

module u8d_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  u8d_pkg::cls_t push_item_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output u8d_pkg::cls_t pop_item_o
);
  import u8d_pkg::*;

  localparam int unsigned AddrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned LevelW = $clog2(QueueDepth + 1);

  cls_t              mem_q [QueueDepth];
  logic [AddrW-1:0]  wptr_q, rptr_q;
  logic [LevelW-1:0] level_q;
  logic              push, pop;

  assign push_ready_o = level_q != LevelW'(QueueDepth);
  assign pop_valid_o  = level_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = mem_q[rptr_q];

  function automatic logic [AddrW-1:0] bump(logic [AddrW-1:0] p);
    return (p == AddrW'(QueueDepth - 1)) ? '0 : p + AddrW'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      level_q <= '0;
    end else begin
      if (push) wptr_q <= bump(wptr_q);
      if (pop)  rptr_q <= bump(rptr_q);
      if (push && !pop) begin
        level_q <= level_q + LevelW'(1);
      end else if (pop && !push) begin
        level_q <= level_q - LevelW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= push_item_i;
    end
  end

endmodule

FILE: hw/rtl/u8d_back.sv
// Back stage: UTF-8 character assembly, error handling and result register.
// Depends on u8d_pkg.

module u8d_back #(
  parameter int unsigned INDEX_BITS = u8d_pkg::IndexBitsDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     pop_valid_i,
  output logic                     pop_ready_o,
  input  u8d_pkg::cls_t            pop_item_i,
  input  logic [u8d_pkg::PosW-1:0] target_index_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output u8d_pkg::res_t            out_res_o
);
  import u8d_pkg::*;

  logic [1:0]            rem_d, rem_q;
  logic [CpW-1:0]        part_d, part_q;
  logic [CountW-1:0]     len_d, len_q;
  logic [INDEX_BITS-1:0] cnt_d, cnt_q;
  logic                  skip_d, skip_q;
  logic                  out_vld_q;
  res_t                  res_d, res_q;
  logic                  pop, emit_char, emit_err;
  status_e               err_st;
  logic [CpW-1:0]        char_cp;
  logic [CountW-1:0]     char_len;
  logic [PosW-1:0]       pos;

  assign pop_ready_o = !out_vld_q || out_ready_i;
  assign pop         = pop_valid_i && pop_ready_o;
  assign pos         = PosW'(cnt_q);

  always_comb begin
    rem_d     = rem_q;
    part_d    = part_q;
    len_d     = len_q;
    cnt_d     = cnt_q;
    skip_d    = skip_q;
    emit_char = 1'b0;
    emit_err  = 1'b0;
    err_st    = ST_INVALID;
    char_cp   = '0;
    char_len  = '0;
    res_d     = '0;

    if (pop) begin
      if (skip_q) begin
        if (pop_item_i.last) begin
          emit_err = 1'b1;
          err_st   = ST_AFTER_ERR;
        end
      end else if (rem_q == '0) begin
        unique case (pop_item_i.kind) inside
          K_ASCII: begin
            emit_char = 1'b1;
            char_cp   = CpW'(pop_item_i.data);
            char_len  = CountW'(1);
          end
          K_LEAD2, K_LEAD3, K_LEAD4: begin
            if (pop_item_i.last) begin
              emit_err = 1'b1;
              err_st   = ST_TRUNC;
            end else begin
              part_d = CpW'(pop_item_i.data);
              len_d  = lead_len(pop_item_i.kind);
              rem_d  = 2'(len_d - CountW'(1));
            end
          end
          default: begin
            emit_err = 1'b1;
            err_st   = ST_INVALID;
          end
        endcase
      end else if (pop_item_i.kind != K_CONT) begin
        emit_err = 1'b1;
        err_st   = ST_INVALID;
      end else begin
        part_d = {part_q[CpW-7:0], pop_item_i.data[5:0]};
        rem_d  = rem_q - 2'd1;
        if (rem_d == '0) begin
          emit_char = 1'b1;
          char_cp   = part_d;
          char_len  = len_q;
        end else if (pop_item_i.last) begin
          emit_err = 1'b1;
          err_st   = ST_TRUNC;
        end
      end

      if (emit_char) begin
        res_d.cp     = char_cp;
        res_d.cnt    = char_len;
        res_d.pos    = pos;
        res_d.sel    = pos == target_index_i;
        res_d.status = ST_OK;
        res_d.last   = pop_item_i.last;
        if (cnt_q != '1) cnt_d = cnt_q + INDEX_BITS'(1);
        rem_d  = '0;
        part_d = '0;
        len_d  = '0;
      end
      if (emit_err) begin
        res_d.cp     = '0;
        res_d.cnt    = '0;
        res_d.pos    = pos;
        res_d.sel    = 1'b0;
        res_d.status = err_st;
        res_d.last   = pop_item_i.last;
        rem_d  = '0;
        part_d = '0;
        len_d  = '0;
        skip_d = 1'b1;
      end
      if ((emit_char || emit_err) && pop_item_i.last) begin
        rem_d  = '0;
        part_d = '0;
        len_d  = '0;
        cnt_d  = '0;
        skip_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q     <= '0;
      part_q    <= '0;
      len_q     <= '0;
      cnt_q     <= '0;
      skip_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      rem_q  <= rem_d;
      part_q <= part_d;
      len_q  <= len_d;
      cnt_q  <= cnt_d;
      skip_q <= skip_d;
      if (pop && (emit_char || emit_err)) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && (emit_char || emit_err)) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_res_o   = res_q;

  a_sel_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && res_q.sel |-> res_q.status == ST_OK)
    else $error("selected result with error status");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && res_q.status != ST_OK |-> res_q.cp == '0 && res_q.cnt == '0)
    else $error("error result carries character data");

  a_ok_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && res_q.status == ST_OK |-> res_q.cnt != '0)
    else $error("ok result with zero byte count");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && pop_item_i.last |=> rem_q == '0 && cnt_q == '0 && !skip_q && out_vld_q)
    else $error("string end did not give a result and clear state");

endmodule

FILE: hw/rtl/utf8_stream_char_decoder_core.sv
// UTF-8 stream decoder top level: front classifier, byte queue, back decoder.
// Bytes pass the front register and the queue; results sit in the output register.
// Throughput: one byte per cycle; front register, 2-entry queue and output register
// each stall independently under back-pressure.
// Reset (rst_ni, asynchronous, low): empties all stages, clears decode state,
// target index returns to 0. Depends on u8d_pkg, u8d_front, u8d_queue, u8d_back.

module utf8_stream_char_decoder_core #(
  parameter int unsigned INDEX_BITS = u8d_pkg::IndexBitsDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [7:0]                  in_byte_i,
  input  logic                        end_of_string_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [u8d_pkg::CpW-1:0]     codepoint_o,
  output logic [u8d_pkg::CountW-1:0]  byte_count_o,
  output logic [u8d_pkg::PosW-1:0]    char_position_o,
  output logic                        is_selected_o,
  output logic [1:0]                  status_o,
  output logic                        last_o,
  input  logic                        target_index_we_i,
  input  logic [u8d_pkg::PosW-1:0]    target_index_i
);
  import u8d_pkg::*;

  logic            push_valid, push_ready, pop_valid, pop_ready;
  cls_t            push_item, pop_item;
  res_t            res;
  logic [PosW-1:0] target_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
    end else if (target_index_we_i) begin
      target_q <= target_index_i;
    end
  end

  u8d_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .in_byte_i,
    .end_of_string_i,
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_item_o  (push_item)
  );

  u8d_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  u8d_back #(
    .INDEX_BITS (INDEX_BITS)
  ) u_back (
    .clk_i,
    .rst_ni,
    .pop_valid_i    (pop_valid),
    .pop_ready_o    (pop_ready),
    .pop_item_i     (pop_item),
    .target_index_i (target_q),
    .out_valid_o,
    .out_ready_i,
    .out_res_o      (res)
  );

  assign codepoint_o     = res.cp;
  assign byte_count_o    = res.cnt;
  assign char_position_o = res.pos;
  assign is_selected_o   = res.sel;
  assign status_o        = res.status;
  assign last_o          = res.last;

endmodule

FILE: bench/testbench.sv
// Self-checking bench for utf8_stream_char_decoder_core: directed table, random strings,
// valid/ready idling and a long output stall.
// Depends on u8d_pkg and the decoder RTL only.

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import u8d_pkg::*;

  localparam int QuietLimit = 2000;
  localparam int PlanRows   = 27;

  typedef struct {
    logic [7:0] b;
    logic       eos;
    logic       typed;
    res_t       want;
  } row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [7:0]        in_byte_i;
  logic              end_of_string_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [CpW-1:0]    codepoint_o;
  logic [CountW-1:0] byte_count_o;
  logic [PosW-1:0]   char_position_o;
  logic              is_selected_o;
  logic [1:0]        status_o;
  logic              last_o;
  logic              target_index_we_i;
  logic [PosW-1:0]   target_index_i;

  // decoder state mirror
  logic [1:0]      need_more;
  logic [CpW-1:0]  acc;
  logic [2:0]      char_len;
  logic [PosW-1:0] char_idx;
  logic            dropping;
  logic [PosW-1:0] sel_target;

  res_t pending_chars[$];
  row_t plan [PlanRows];
  logic row_typed;
  res_t row_want;
  bit   calm;
  int   in_count;
  int   errors;
  int   quiet;

  utf8_stream_char_decoder_core uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .in_byte_i         (in_byte_i),
    .end_of_string_i   (end_of_string_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .codepoint_o       (codepoint_o),
    .byte_count_o      (byte_count_o),
    .char_position_o   (char_position_o),
    .is_selected_o     (is_selected_o),
    .status_o          (status_o),
    .last_o            (last_o),
    .target_index_we_i (target_index_we_i),
    .target_index_i    (target_index_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic res_t char_res(logic [CpW-1:0] cp, logic [2:0] n, logic [PosW-1:0] pos,
                                    logic sel, status_e st, logic last);
    res_t r;
    r.cp     = cp;
    r.cnt    = n;
    r.pos    = pos;
    r.sel    = sel;
    r.status = st;
    r.last   = last;
    return r;
  endfunction

  task automatic decode_byte(input logic [7:0] b, input logic eos,
                             output logic has, output res_t r);
    logic [CpW-1:0] cp;
    logic [2:0]     n;
    logic [2:0]     len;
    logic [CpW-1:0] bits;
    status_e        st;
    has  = 1'b0;
    cp   = '0;
    n    = '0;
    len  = '0;
    bits = '0;
    st   = ST_OK;
    r    = '0;
    if (dropping) begin
      if (eos) begin
        has = 1'b1;
        st  = ST_AFTER_ERR;
      end
    end else if (need_more == 2'd0) begin
      if (!b[7]) begin
        has = 1'b1;
        cp  = CpW'(b);
        n   = 3'd1;
      end else if (b[7:5] == 3'b110) begin
        len  = 3'd2;
        bits = CpW'(b[4:0]);
      end else if (b[7:4] == 4'b1110) begin
        len  = 3'd3;
        bits = CpW'(b[3:0]);
      end else if (b[7:3] == 5'b11110) begin
        len  = 3'd4;
        bits = CpW'(b[2:0]);
      end else begin
        has = 1'b1;
        st  = ST_INVALID;
      end
      if (len != 3'd0) begin
        if (eos) begin
          has = 1'b1;
          st  = ST_TRUNC;
        end else begin
          acc       = bits;
          char_len  = len;
          need_more = 2'(len - 3'd1);
        end
      end
    end else if (b[7:6] != 2'b10) begin
      has = 1'b1;
      st  = ST_INVALID;
    end else begin
      acc       = {acc[CpW-7:0], b[5:0]};
      need_more = need_more - 2'd1;
      if (need_more == 2'd0) begin
        has = 1'b1;
        cp  = acc;
        n   = char_len;
      end else if (eos) begin
        has = 1'b1;
        st  = ST_TRUNC;
      end
    end

    if (has) begin
      r = char_res(cp, n, char_idx, (st == ST_OK) && (char_idx == sel_target), st, eos);
      need_more = '0;
      acc       = '0;
      char_len  = '0;
      if (st == ST_OK) begin
        if (char_idx != '1) char_idx = char_idx + 1'b1;
      end else if (!eos) begin
        dropping = 1'b1;
      end
      if (eos) begin
        char_idx = '0;
        dropping = 1'b0;
      end
    end
  endtask

  task automatic report(string field, int unsigned want, int unsigned got);
    errors++;
    $display("%0t ns: %s expected %0h actual %0h", $time, field, want, got);
  endtask

  task automatic check_char(res_t want);
    if (want.cp != codepoint_o)       report("codepoint", want.cp, codepoint_o);
    if (want.cnt != byte_count_o)     report("byte_count", want.cnt, byte_count_o);
    if (want.pos != char_position_o)  report("char_position", want.pos, char_position_o);
    if (want.sel != is_selected_o)    report("is_selected", want.sel, is_selected_o);
    if (want.status != status_o)      report("status", want.status, status_o);
    if (want.last != last_o)          report("last", want.last, last_o);
  endtask

  always @(posedge clk_i) begin
    logic has;
    res_t r;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_chars.size() == 0) begin
          errors++;
          $display("%0t ns: result with nothing expected, codepoint %0h status %0d",
                   $time, codepoint_o, status_o);
        end else begin
          check_char(pending_chars.pop_front());
        end
      end
      if (in_valid_i && in_ready_o) begin
        decode_byte(in_byte_i, end_of_string_i, has, r);
        if (has) pending_chars.push_back(row_typed ? row_want : r);
        in_count++;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet + 1 >= QuietLimit) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    bit held;
    held        = 1'b0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!held && in_count >= 150) begin
        held = 1'b1;
        out_ready_i <= 1'b0;
        repeat (59) @(negedge clk_i);
      end else begin
        out_ready_i <= calm || ($urandom_range(99) >= 14);
      end
    end
  end

  task automatic put_byte(input logic [7:0] b, input logic eos, input logic typed,
                          input res_t want);
    @(negedge clk_i);
    while (!calm && $urandom_range(99) < 14) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    row_typed = typed;
    row_want  = want;
    in_valid_i      <= 1'b1;
    in_byte_i       <= b;
    end_of_string_i <= eos;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic set_target(input logic [PosW-1:0] v);
    drain();
    @(negedge clk_i);
    target_index_we_i <= 1'b1;
    target_index_i    <= v;
    @(negedge clk_i);
    target_index_we_i <= 1'b0;
    sel_target = v;
  endtask

  task automatic send_random_string();
    logic [7:0] bytes[$];
    int         nchars;
    int         mode;
    int         len;
    int         p;
    int         top;
    int         good;
    nchars = $urandom_range(1, 10);
    mode   = $urandom_range(99);
    p      = $urandom_range(0, nchars - 1);
    if (mode >= 92) begin
      repeat ($urandom_range(1, 8)) bytes.push_back(8'($urandom));
    end else begin
      for (int i = 0; i < nchars; i++) begin
        if (i == p && mode >= 70 && mode < 78) begin
          if ($urandom_range(1))
            bytes.push_back({2'b10, 6'($urandom)});
          else
            bytes.push_back({5'b11111, 3'($urandom)});
        end
        if (i == p && mode >= 78 && mode < 85) begin
          len  = $urandom_range(2, 4);
          good = $urandom_range(0, len - 2);
          case (len)
            2: bytes.push_back({3'b110, 5'($urandom)});
            3: bytes.push_back({4'b1110, 4'($urandom)});
            default: bytes.push_back({5'b11110, 3'($urandom)});
          endcase
          repeat (good) bytes.push_back({2'b10, 6'($urandom)});
          top = $urandom_range(0, 2);
          if (top == 2) top = 3;
          bytes.push_back({2'(top), 6'($urandom)});
        end
        len = $urandom_range(1, 4);
        case (len)
          1: bytes.push_back({1'b0, 7'($urandom)});
          2: bytes.push_back({3'b110, 5'($urandom)});
          3: bytes.push_back({4'b1110, 4'($urandom)});
          default: bytes.push_back({5'b11110, 3'($urandom)});
        endcase
        repeat (len - 1) bytes.push_back({2'b10, 6'($urandom)});
      end
      if (mode >= 85) begin
        len = $urandom_range(2, 4);
        case (len)
          2: bytes.push_back({3'b110, 5'($urandom)});
          3: bytes.push_back({4'b1110, 4'($urandom)});
          default: bytes.push_back({5'b11110, 3'($urandom)});
        endcase
        repeat ($urandom_range(0, len - 2)) bytes.push_back({2'b10, 6'($urandom)});
      end
    end
    foreach (bytes[i]) put_byte(bytes[i], i == bytes.size() - 1, 1'b0, '0);
  endtask

  initial begin
    int           stop;
    logic [PosW-1:0] phase_target [5];
    in_valid_i        = 1'b0;
    in_byte_i         = '0;
    end_of_string_i   = 1'b0;
    target_index_we_i = 1'b0;
    target_index_i    = '0;
    rst_ni            = 1'b0;
    calm              = 1'b0;
    row_typed         = 1'b0;
    row_want          = '0;
    in_count          = 0;
    errors            = 0;
    need_more         = '0;
    acc               = '0;
    char_len          = '0;
    char_idx          = '0;
    dropping          = 1'b0;
    sel_target        = '0;

    plan = '{
      '{8'h00, 1'b0, 1'b1, char_res(21'h0,      3'd1, 16'd0, 1'b1, ST_OK,        1'b0)},
      '{8'h7F, 1'b0, 1'b1, char_res(21'h7F,     3'd1, 16'd1, 1'b0, ST_OK,        1'b0)},
      '{8'hC2, 1'b0, 1'b0, '0},
      '{8'h80, 1'b0, 1'b1, char_res(21'h80,     3'd2, 16'd2, 1'b0, ST_OK,        1'b0)},
      '{8'hE0, 1'b0, 1'b0, '0},
      '{8'hA0, 1'b0, 1'b0, '0},
      '{8'h80, 1'b0, 1'b1, char_res(21'h800,    3'd3, 16'd3, 1'b0, ST_OK,        1'b0)},
      '{8'hF4, 1'b0, 1'b0, '0},
      '{8'h8F, 1'b0, 1'b0, '0},
      '{8'hBF, 1'b0, 1'b0, '0},
      '{8'hBF, 1'b0, 1'b1, char_res(21'h10FFFF, 3'd4, 16'd4, 1'b0, ST_OK,        1'b0)},
      '{8'hF7, 1'b0, 1'b0, '0},
      '{8'hBF, 1'b0, 1'b0, '0},
      '{8'hBF, 1'b0, 1'b0, '0},
      '{8'hBF, 1'b0, 1'b1, char_res(21'h1FFFFF, 3'd4, 16'd5, 1'b0, ST_OK,        1'b0)},
      '{8'h41, 1'b1, 1'b1, char_res(21'h41,     3'd1, 16'd6, 1'b0, ST_OK,        1'b1)},
      '{8'hFF, 1'b0, 1'b1, char_res(21'h0,      3'd0, 16'd0, 1'b0, ST_INVALID,   1'b0)},
      '{8'h41, 1'b0, 1'b0, '0},
      '{8'h80, 1'b1, 1'b1, char_res(21'h0,      3'd0, 16'd0, 1'b0, ST_AFTER_ERR, 1'b1)},
      '{8'hE2, 1'b0, 1'b0, '0},
      '{8'h28, 1'b0, 1'b1, char_res(21'h0,      3'd0, 16'd0, 1'b0, ST_INVALID,   1'b0)},
      '{8'h00, 1'b1, 1'b1, char_res(21'h0,      3'd0, 16'd0, 1'b0, ST_AFTER_ERR, 1'b1)},
      '{8'hF0, 1'b0, 1'b0, '0},
      '{8'h90, 1'b1, 1'b1, char_res(21'h0,      3'd0, 16'd0, 1'b0, ST_TRUNC,     1'b1)},
      '{8'hC3, 1'b1, 1'b1, char_res(21'h0,      3'd0, 16'd0, 1'b0, ST_TRUNC,     1'b1)},
      '{8'h80, 1'b1, 1'b1, char_res(21'h0,      3'd0, 16'd0, 1'b0, ST_INVALID,   1'b1)},
      '{8'h00, 1'b1, 1'b1, char_res(21'h0,      3'd1, 16'd0, 1'b1, ST_OK,        1'b1)}
    };

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i]) put_byte(plan[i].b, plan[i].eos, plan[i].typed, plan[i].want);

    phase_target[0] = 16'hFFFF;
    phase_target[1] = 16'($urandom_range(1, 6));
    phase_target[2] = 16'($urandom_range(0, 3));
    phase_target[3] = 16'($urandom);
    phase_target[4] = 16'h0000;
    for (int ph = 0; ph < 5; ph++) begin
      set_target(phase_target[ph]);
      calm = (ph == 2);
      stop = in_count + 160;
      while (in_count < stop) send_random_string();
    end
    calm = 1'b0;

    drain();
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/u8d_pkg.sv
hw/rtl/u8d_front.sv
hw/rtl/u8d_queue.sv
hw/rtl/u8d_back.sv
hw/rtl/utf8_stream_char_decoder_core.sv
bench/testbench.sv
